// ===== src/planar_odometry_integrator_core_assert.svh =====
// ============================================================================
// Assertion macros for the planar odometry integrator
// Clocked property helpers that the top level uses for its checks.
// ============================================================================
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define POI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define POI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/poi_pkg.sv =====
// ============================================================================
// poi_pkg
// Shared types, opcodes and constants of the planar odometry integrator.
// ============================================================================
package poi_pkg;

    localparam int S_TDATA_W  = 56;     // 52 field bits padded to whole bytes
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_N     = 24;

    // multiplier operand select
    localparam int MOP_W    = 4;
    localparam logic [MOP_W-1:0] MOP_NONE = 4'd0;
    localparam logic [MOP_W-1:0] MOP_VDT  = 4'd1;
    localparam logic [MOP_W-1:0] MOP_WDT  = 4'd2;
    localparam logic [MOP_W-1:0] MOP_HLO  = 4'd3;
    localparam logic [MOP_W-1:0] MOP_HHI  = 4'd4;
    localparam logic [MOP_W-1:0] MOP_CLO  = 4'd5;
    localparam logic [MOP_W-1:0] MOP_CHI  = 4'd6;
    localparam logic [MOP_W-1:0] MOP_SLO  = 4'd7;
    localparam logic [MOP_W-1:0] MOP_SHI  = 4'd8;

    // product writeback select
    localparam int WOP_W    = 4;
    localparam logic [WOP_W-1:0] WOP_NONE = 4'd0;
    localparam logic [WOP_W-1:0] WOP_P    = 4'd1;
    localparam logic [WOP_W-1:0] WOP_MAG  = 4'd2;
    localparam logic [WOP_W-1:0] WOP_HACC = 4'd3;
    localparam logic [WOP_W-1:0] WOP_HADD = 4'd4;
    localparam logic [WOP_W-1:0] WOP_HEAD = 4'd5;
    localparam logic [WOP_W-1:0] WOP_PACC = 4'd6;
    localparam logic [WOP_W-1:0] WOP_PADD = 4'd7;
    localparam logic [WOP_W-1:0] WOP_X    = 4'd8;
    localparam logic [WOP_W-1:0] WOP_Y    = 4'd9;

    localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;  // gain 0.60725 in Q2.30
    localparam logic [31:0]        RAD_TO_BAM = 32'd2935890503;  // 2^64 / (2*pi*1e9)

    localparam logic [31:0] ATAN_BAM [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                  latch_in;
        logic                  cordic_load;
        logic                  cordic_half;  // load heading/2 instead of heading
        logic                  cordic_iter;
        logic [ATAN_IDX_W-1:0] iter_idx;
        logic [MOP_W-1:0]      mul_sel;
        logic [WOP_W-1:0]      wr_sel;
        logic                  latch_cs;
        logic                  out_load;
    } poi_cmd_t;

endpackage

// ===== src/poi_datapath.sv =====
// ============================================================================
// poi_datapath
// CORDIC, shared multiplier/accumulator, pose registers and output register.
// ============================================================================
module poi_datapath
    import poi_pkg::*;
#(
    parameter int POS_WIDTH = 48,
    parameter int M_TDATA_W = 192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  poi_cmd_t             cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DX_W   = 40;
    localparam int SUM_W  = ((POS_WIDTH > DX_W) ? POS_WIDTH : DX_W) + 1;
    localparam int M_BITS = 2 * POS_WIDTH + 96;

    // input latch
    logic signed [15:0] v_reg, w_reg;
    logic        [19:0] dt_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               flip_reg;
    logic        [31:0] ang, ang_q, ang_r;
    logic signed [33:0] xs, ys, c_val, s_val, c_rnd, s_rnd, qz_rnd, qw_rnd;
    logic signed [32:0] atan_v;
    logic signed [26:0] c24_reg, s24_reg;
    logic signed [15:0] qz, qw;

    // multiplier and accumulator
    logic signed [26:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [59:0] prod_reg;
    logic signed [59:0] prod_neg;
    logic        [63:0] prod_ext;
    logic        [63:0] acc_reg;
    logic signed [36:0] p_reg;
    logic        [34:0] mag_reg;
    logic               neg_reg;

    // pose
    logic signed [POS_WIDTH-1:0] x_reg, y_reg;
    logic        [31:0]          heading_reg;
    logic        [M_BITS-1:0]    out_fields;
    logic        [M_TDATA_W-1:0] m_tdata_reg;

    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] a,
        input logic signed [DX_W-1:0]      d
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] pmax;
        logic signed [SUM_W-1:0] pmin;
        sum  = SUM_W'(a) + SUM_W'(d);
        pmax = {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
        pmin = ~pmax;
        if (sum > pmax) begin
            sum = pmax;
        end else if (sum < pmin) begin
            sum = pmin;
        end
        return sum[POS_WIDTH-1:0];
    endfunction

    function automatic logic signed [15:0] q15_clamp(input logic signed [33:0] r);
        logic signed [15:0] q;
        if (r > 34'sd32767) begin
            q = 16'sd32767;
        end else if (r < -34'sd32767) begin
            q = -16'sd32767;
        end else begin
            q = r[15:0];
        end
        return q;
    endfunction

    // ---- CORDIC ----
    // Angles in [pi/2, 3pi/2) are turned by pi; results negated on the way out.
    assign ang   = cmd.cordic_half ? {1'b0, heading_reg[31:1]} : heading_reg;
    assign ang_q = ang + 32'h4000_0000;
    assign ang_r = ang_q[31] ? (ang ^ 32'h8000_0000) : ang;

    assign xs     = cx_reg >>> cmd.iter_idx;
    assign ys     = cy_reg >>> cmd.iter_idx;
    assign atan_v = {1'b0, ATAN_BAM[cmd.iter_idx]};

    always_ff @(posedge aclk) begin
        if (cmd.cordic_load) begin
            cx_reg   <= CORDIC_X0;
            cy_reg   <= '0;
            cz_reg   <= {ang_r[31], ang_r};
            flip_reg <= ang_q[31];
        end else if (cmd.cordic_iter) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
        end
    end

    assign c_val  = flip_reg ? -cx_reg : cx_reg;
    assign s_val  = flip_reg ? -cy_reg : cy_reg;
    assign c_rnd  = (c_val + 34'sd32) >>> 6;        // Q2.30 -> Q2.24
    assign s_rnd  = (s_val + 34'sd32) >>> 6;
    assign qw_rnd = (c_val + 34'sd16384) >>> 15;     // Q2.30 -> Q1.15
    assign qz_rnd = (s_val + 34'sd16384) >>> 15;
    assign qw     = q15_clamp(qw_rnd);
    assign qz     = q15_clamp(qz_rnd);

    always_ff @(posedge aclk) begin
        if (cmd.latch_cs) begin
            c24_reg <= c_rnd[26:0];
            s24_reg <= s_rnd[26:0];
        end
        if (cmd.latch_in) begin
            v_reg  <= s_tdata[15:0];
            w_reg  <= s_tdata[31:16];
            dt_reg <= s_tdata[51:32];
        end
    end

    // ---- shared multiplier ----
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MOP_VDT: begin
                mul_a = {{11{v_reg[15]}}, v_reg};
                mul_b = {13'd0, dt_reg};
            end
            MOP_WDT: begin
                mul_a = {{11{w_reg[15]}}, w_reg};
                mul_b = {13'd0, dt_reg};
            end
            MOP_HLO: begin
                mul_a = {9'd0, mag_reg[17:0]};
                mul_b = {1'b0, RAD_TO_BAM};
            end
            MOP_HHI: begin
                mul_a = {10'd0, mag_reg[34:18]};
                mul_b = {1'b0, RAD_TO_BAM};
            end
            MOP_CLO: begin
                mul_a = c24_reg;
                mul_b = {17'd0, p_reg[15:0]};
            end
            MOP_CHI: begin
                mul_a = c24_reg;
                mul_b = {{12{p_reg[36]}}, p_reg[36:16]};
            end
            MOP_SLO: begin
                mul_a = s24_reg;
                mul_b = {17'd0, p_reg[15:0]};
            end
            MOP_SHI: begin
                mul_a = s24_reg;
                mul_b = {{12{p_reg[36]}}, p_reg[36:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_sel != MOP_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod_neg = -prod_reg;
    assign prod_ext = {{4{prod_reg[59]}}, prod_reg};

    // ---- writeback: accumulator, heading and position ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            heading_reg <= '0;
        end else begin
            case (cmd.wr_sel)
                WOP_NONE: ;
                WOP_P: p_reg <= prod_reg[36:0];
                WOP_MAG: begin
                    neg_reg <= prod_reg[59];
                    mag_reg <= prod_reg[59] ? prod_neg[34:0] : prod_reg[34:0];
                end
                WOP_HACC: acc_reg <= prod_ext + 64'h0000_0000_8000_0000;
                WOP_HADD: acc_reg <= acc_reg + (prod_ext << 18);
                WOP_HEAD: begin
                    // step = round(|w*dt| * 2^32 / (2*pi*1e9)), applied with sign
                    if (neg_reg) begin
                        heading_reg <= heading_reg - acc_reg[63:32];
                    end else begin
                        heading_reg <= heading_reg + acc_reg[63:32];
                    end
                end
                WOP_PACC: acc_reg <= prod_ext + 64'h0000_0000_0080_0000;
                WOP_PADD: acc_reg <= acc_reg + (prod_ext << 16);
                WOP_X: x_reg <= sat_add(x_reg, acc_reg[63:24]);
                WOP_Y: y_reg <= sat_add(y_reg, acc_reg[63:24]);
                default: ;
            endcase
        end
    end

    // ---- output register ----
    assign out_fields = {w_reg, v_reg, qw, qz, heading_reg, y_reg, x_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'(out_fields);
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ===== src/poi_ctrl.sv =====
// ============================================================================
// poi_ctrl
// Sequencer for one odometry update: two CORDIC runs with multiplies overlaid.
// ============================================================================
module poi_ctrl
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output poi_cmd_t cmd
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN1 = 3'd1;   // CORDIC of heading, heading update
    localparam logic [2:0] ST_MID  = 3'd2;
    localparam logic [2:0] ST_RUN2 = 3'd3;   // CORDIC of heading/2, x/y update
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.iter_idx = ATAN_IDX_W'(step_reg);
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    cmd.latch_in    = 1'b1;
                    cmd.cordic_load = 1'b1;
                    state_next      = ST_RUN1;
                end
            end
            ST_RUN1: begin
                cmd.cordic_iter = 1'b1;
                step_next       = step_reg + 1'b1;
                case (step_reg)
                    STEP_W'(0): cmd.mul_sel = MOP_VDT;
                    STEP_W'(1): begin
                        cmd.wr_sel  = WOP_P;
                        cmd.mul_sel = MOP_WDT;
                    end
                    STEP_W'(2): cmd.wr_sel = WOP_MAG;
                    STEP_W'(3): cmd.mul_sel = MOP_HLO;
                    STEP_W'(4): begin
                        cmd.wr_sel  = WOP_HACC;
                        cmd.mul_sel = MOP_HHI;
                    end
                    STEP_W'(5): cmd.wr_sel = WOP_HADD;
                    STEP_W'(6): cmd.wr_sel = WOP_HEAD;
                    default: ;
                endcase
                if (last_step) begin
                    step_next  = '0;
                    state_next = ST_MID;
                end
            end
            ST_MID: begin
                cmd.latch_cs    = 1'b1;
                cmd.cordic_load = 1'b1;
                cmd.cordic_half = 1'b1;
                state_next      = ST_RUN2;
            end
            ST_RUN2: begin
                cmd.cordic_iter = 1'b1;
                step_next       = step_reg + 1'b1;
                case (step_reg)
                    STEP_W'(0): cmd.mul_sel = MOP_CLO;
                    STEP_W'(1): begin
                        cmd.wr_sel  = WOP_PACC;
                        cmd.mul_sel = MOP_CHI;
                    end
                    STEP_W'(2): cmd.wr_sel = WOP_PADD;
                    STEP_W'(3): begin
                        cmd.wr_sel  = WOP_X;
                        cmd.mul_sel = MOP_SLO;
                    end
                    STEP_W'(4): begin
                        cmd.wr_sel  = WOP_PACC;
                        cmd.mul_sel = MOP_SHI;
                    end
                    STEP_W'(5): cmd.wr_sel = WOP_PADD;
                    STEP_W'(6): cmd.wr_sel = WOP_Y;
                    default: ;
                endcase
                if (last_step) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== src/planar_odometry_integrator_core.sv =====
// ============================================================================
// planar_odometry_integrator_core
// Dead-reckoning pose integrator: x/y/heading update plus yaw quaternion.
// ============================================================================
//
//  channel | direction | tdata fields (lowest bit first)
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | fwd_speed, angular_rate, step_time
//  m_      | out       | pos_x, pos_y, heading, quat_z, quat_w,
//          |           | twist_linear, twist_angular
//
//  After accept the sequencer steps through RUN1, MID, RUN2 and DONE, and the
//  result is valid once DONE has loaded the output register. A beat is only
//  taken in IDLE, so no new update starts before the last result is loaded.
//  The single shared CORDIC runs once on the old heading and once on half the
//  new heading. All multiplies share one 27x33 multiplier and overlap the
//  CORDIC iterations.
//  Reset clears the pose to zero; no clearing pass, s_tready is up in the
//  first cycle after reset. A stalled result sits in the output register
//  and holds the sequencer in its final state until m_tready.
//
`include "planar_odometry_integrator_core_assert.svh"

module planar_odometry_integrator_core
    import poi_pkg::*;
#(
    parameter int  POS_WIDTH    = 48,
    parameter int  CORDIC_STEPS = 16,
    localparam int M_TDATA_W    = ((2 * POS_WIDTH + 96 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] fwd_speed, [31:16] angular_rate, [51:32] step_time, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pos_x, pos_y (POS_WIDTH each), heading (32), quat_z, quat_w,
    // twist_linear, twist_angular (16 each), zero padded to whole bytes
    output logic [M_TDATA_W-1:0] m_tdata
);

    poi_cmd_t cmd;
    logic     s_beat;
    logic     m_free;
    logic     vdt_mul;

    // Sequencer: owns the handshake and issues one command word per cycle.
    poi_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: CORDIC, multiplier/accumulator, pose state, output register.
    poi_datapath #(
        .POS_WIDTH (POS_WIDTH),
        .M_TDATA_W (M_TDATA_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

    // ---- checks ----
    assign s_beat  = s_tvalid && s_tready;
    assign m_free  = !m_tvalid || m_tready;
    assign vdt_mul = (cmd.mul_sel == MOP_VDT);

    // once a beat is taken the block is busy for the next cycle
    `POI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_beat, !s_tready, "beat taken while busy")
    // the output register is only overwritten when empty or being drained
    `POI_ASSERT_SAME(a_no_clobber, aclk, aresetn, cmd.out_load, m_free, "result overwritten")
    // the first multiply after accept is the distance product
    `POI_ASSERT_NEXT(a_first_mul, aclk, aresetn, s_beat, vdt_mul, "schedule out of step")

endmodule
